// ===== rtl/core/sa2v_pkg.sv =====
// Shared types, fixed-point constants and the arctangent table for the signed
// angle block. No dependencies; every other file of the block imports it.
`default_nettype none

package sa2v_pkg;

    // Working width of the dot/cross datapath and of the rotation stages.
    localparam int ACC_W       = 64;
    // Angle accumulator width, Q.20 radians, holds +/- (pi/2 + sum of atan steps).
    localparam int ZW          = 24;
    localparam int ANGLE_W     = 16;
    localparam int ANGLE_FRAC  = 20;
    localparam int OUT_FRAC    = 13;
    localparam int ROUND_SHIFT = ANGLE_FRAC - OUT_FRAC;
    // Normalization moves the larger magnitude up to at least 2^NORM_MSB.
    localparam int NORM_MSB    = 56;
    localparam int NORM_STEPS  = 6;
    localparam int TABLE_SIZE  = 24;

    localparam logic signed [ZW-1:0]      HALF_PI_ACC = 24'sd1647099;
    localparam logic signed [ANGLE_W-1:0] PI_OUT      = 16'sd25736;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [ACC_W-1:0]        t_mag;
    typedef logic signed [ZW-1:0]    t_z;

    // Sideband that travels with each item down the pipeline.
    typedef struct packed {
        logic zero_length;
        logic collinear;
        logic dot_pos;
    } t_flags;

    // Arctangent of 2^-idx in Q.20, rounded to nearest.
    function automatic t_z atan_entry(input logic [4:0] idx);
        t_z v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sa2v_if.sv =====
// Valid/ready channels of the signed angle block: the vector pair input and
// the angle result. Depends on sa2v_pkg for the result width.
`default_nettype none

interface sa2v_pair_if #(parameter int COMPONENT_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] first_x;
    logic signed [COMPONENT_WIDTH-1:0] first_y;
    logic signed [COMPONENT_WIDTH-1:0] second_x;
    logic signed [COMPONENT_WIDTH-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface sa2v_angle_if;
    import sa2v_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;
    logic                      zero_length;

    modport source (output valid, angle, zero_length, input ready);
    modport sink   (input valid, angle, zero_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sa2v_cordic_stage.sv =====
// One registered vectoring rotation of the angle pipeline.
// Depends on sa2v_pkg for the datapath types and the arctangent table.
`default_nettype none

module sa2v_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sa2v_pkg::t_flags i_flags,
    input  sa2v_pkg::t_acc  i_x,
    input  sa2v_pkg::t_acc  i_y,
    input  sa2v_pkg::t_z    i_z,
    output logic            o_valid,
    output sa2v_pkg::t_flags o_flags,
    output sa2v_pkg::t_acc  o_x,
    output sa2v_pkg::t_acc  o_y,
    output sa2v_pkg::t_z    o_z
);
    import sa2v_pkg::*;

    localparam t_z ANGLE_STEP = atan_entry(5'(STAGE));

    logic   r_valid;
    t_flags r_flags;
    t_acc   r_x, r_y;
    t_z     r_z;
    t_acc   n_x, n_y;
    t_z     n_z;
    t_acc   dx, dy;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_y[ACC_W-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANGLE_STEP;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANGLE_STEP;
        end
    end

    // Valid bit is control and resets; the rest is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

`default_nettype wire

// ===== rtl/core/signed_angle_2d_vectors_top.sv =====
// Signed angle from a first 2D vector to a second, as atan2(cross, dot) in Q3.13.
// Pipeline: products, dot and cross, quarter turn, normalization steps, rotations, output register.
// Throughput: one vector pair per cycle; a stall freezes the whole pipeline, and a
// one-entry skid buffer at the input keeps the input ready a registered signal.
// Reset (synchronous, active low) clears all valid bits and the skid buffer.
// Uses sa2v_pkg, the channel interfaces and sa2v_cordic_stage.
`default_nettype none

module signed_angle_2d_vectors_top #(
    parameter int COMPONENT_WIDTH  = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sa2v_pair_if.sink     i_pair,
    sa2v_angle_if.source  o_angle
);
    import sa2v_pkg::*;

    localparam int CW         = COMPONENT_WIDTH;
    localparam int PROD_W     = 2 * CW;
    localparam bit PRE_HALVE  = (2 * CW > 62);
    localparam int N          = ANGLE_ITERATIONS;

    // Global advance: the pipeline moves whenever the output register is free.
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || o_angle.ready;

    // Input skid buffer.
    logic                 r_skid_full;
    logic signed [CW-1:0] r_skid_ax, r_skid_ay, r_skid_bx, r_skid_by;
    logic                 in_xfer;
    logic                 src_valid;
    logic signed [CW-1:0] src_ax, src_ay, src_bx, src_by;

    assign i_pair.ready = !r_skid_full;
    assign in_xfer      = i_pair.valid && !r_skid_full;
    assign src_valid    = r_skid_full || in_xfer;
    assign src_ax       = r_skid_full ? r_skid_ax : i_pair.first_x;
    assign src_ay       = r_skid_full ? r_skid_ay : i_pair.first_y;
    assign src_bx       = r_skid_full ? r_skid_bx : i_pair.second_x;
    assign src_by       = r_skid_full ? r_skid_by : i_pair.second_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (en) begin
            r_skid_full <= 1'b0;
        end else if (in_xfer) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_xfer) begin
            r_skid_ax <= i_pair.first_x;
            r_skid_ay <= i_pair.first_y;
            r_skid_bx <= i_pair.second_x;
            r_skid_by <= i_pair.second_y;
        end
    end

    // Stage 1: the four component products and the zero-length check.
    logic                     r_s1_valid;
    logic                     r_s1_zero;
    logic signed [PROD_W-1:0] r_p_axbx, r_p_ayby, r_p_axby, r_p_aybx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_zero <= ((src_ax == '0) && (src_ay == '0)) ||
                         ((src_bx == '0) && (src_by == '0));
            r_p_axbx  <= PROD_W'(src_ax) * PROD_W'(src_bx);
            r_p_ayby  <= PROD_W'(src_ay) * PROD_W'(src_by);
            r_p_axby  <= PROD_W'(src_ax) * PROD_W'(src_by);
            r_p_aybx  <= PROD_W'(src_ay) * PROD_W'(src_bx);
        end
    end

    // Stage 2: dot and cross products; very wide components halve each product first.
    logic r_s2_valid;
    logic r_s2_zero;
    t_acc r_s2_dot, r_s2_cross;
    t_acc e_axbx, e_ayby, e_axby, e_aybx;

    always_comb begin
        e_axbx = t_acc'(r_p_axbx);
        e_ayby = t_acc'(r_p_ayby);
        e_axby = t_acc'(r_p_axby);
        e_aybx = t_acc'(r_p_aybx);
        if (PRE_HALVE) begin
            e_axbx = e_axbx >>> 1;
            e_ayby = e_ayby >>> 1;
            e_axby = e_axby >>> 1;
            e_aybx = e_aybx >>> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_zero  <= r_s1_zero;
            r_s2_dot   <= e_axbx + e_ayby;
            r_s2_cross <= e_axby - e_aybx;
        end
    end

    // Stage 3: rotate a negative-dot vector by a quarter turn into the right half plane.
    logic   r_s3_valid;
    t_flags r_s3_flags;
    t_acc   r_s3_x, r_s3_y;
    t_mag   r_s3_m;
    t_z     r_s3_z;
    t_acc   n_s3_x, n_s3_y;
    t_mag   n_s3_m;
    t_z     n_s3_z;
    t_acc   neg_dot, neg_cross;
    t_flags n_s3_flags;

    always_comb begin
        neg_dot   = -r_s2_dot;
        neg_cross = -r_s2_cross;
        n_s3_flags.zero_length = r_s2_zero;
        n_s3_flags.collinear   = (r_s2_cross == '0);
        n_s3_flags.dot_pos     = !r_s2_dot[ACC_W-1] && (r_s2_dot != '0);
        if (r_s2_dot[ACC_W-1]) begin
            n_s3_m = t_mag'(neg_dot);
            if (!r_s2_cross[ACC_W-1]) begin
                n_s3_x = r_s2_cross;
                n_s3_y = neg_dot;
                n_s3_z = HALF_PI_ACC;
            end else begin
                n_s3_x = neg_cross;
                n_s3_y = r_s2_dot;
                n_s3_z = -HALF_PI_ACC;
            end
        end else begin
            n_s3_x = r_s2_dot;
            n_s3_y = r_s2_cross;
            n_s3_z = '0;
            n_s3_m = r_s2_cross[ACC_W-1] ? t_mag'(neg_cross) : t_mag'(r_s2_cross);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_flags <= n_s3_flags;
            r_s3_x     <= n_s3_x;
            r_s3_y     <= n_s3_y;
            r_s3_m     <= n_s3_m;
            r_s3_z     <= n_s3_z;
        end
    end

    // Normalization: binary shift search, one conditional shift per stage.
    // x is never negative here, so OR-ing it with |y| tests the larger magnitude.
    logic   nrm_valid [0:NORM_STEPS];
    t_flags nrm_flags [0:NORM_STEPS];
    t_acc   nrm_x     [0:NORM_STEPS];
    t_acc   nrm_y     [0:NORM_STEPS];
    t_mag   nrm_m     [0:NORM_STEPS];
    t_z     nrm_z     [0:NORM_STEPS];

    assign nrm_valid[0] = r_s3_valid;
    assign nrm_flags[0] = r_s3_flags;
    assign nrm_x[0]     = r_s3_x;
    assign nrm_y[0]     = r_s3_y;
    assign nrm_m[0]     = r_s3_m;
    assign nrm_z[0]     = r_s3_z;

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH  = 32 >> j;
        localparam int TOP = NORM_MSB + 1 - SH;

        logic   r_valid;
        t_flags r_flags;
        t_acc   r_x, r_y;
        t_mag   r_m;
        t_z     r_z;
        logic   can_shift;

        assign can_shift = ((t_mag'(nrm_x[j]) | nrm_m[j]) >> TOP) == '0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (en) begin
                r_valid <= nrm_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_flags <= nrm_flags[j];
                r_z     <= nrm_z[j];
                r_x     <= can_shift ? (nrm_x[j] <<< SH) : nrm_x[j];
                r_y     <= can_shift ? (nrm_y[j] <<< SH) : nrm_y[j];
                r_m     <= can_shift ? (nrm_m[j] << SH) : nrm_m[j];
            end
        end

        assign nrm_valid[j+1] = r_valid;
        assign nrm_flags[j+1] = r_flags;
        assign nrm_x[j+1]     = r_x;
        assign nrm_y[j+1]     = r_y;
        assign nrm_m[j+1]     = r_m;
        assign nrm_z[j+1]     = r_z;
    end

    // Vectoring rotations, one registered stage per iteration.
    logic   cor_valid [0:N];
    t_flags cor_flags [0:N];
    t_acc   cor_x     [0:N];
    t_acc   cor_y     [0:N];
    t_z     cor_z     [0:N];

    assign cor_valid[0] = nrm_valid[NORM_STEPS];
    assign cor_flags[0] = nrm_flags[NORM_STEPS];
    assign cor_x[0]     = nrm_x[NORM_STEPS];
    assign cor_y[0]     = nrm_y[NORM_STEPS];
    assign cor_z[0]     = nrm_z[NORM_STEPS];

    for (genvar k = 0; k < N; k++) begin : g_cordic
        sa2v_cordic_stage #(.STAGE(k)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cor_valid[k]),
            .i_flags (cor_flags[k]),
            .i_x     (cor_x[k]),
            .i_y     (cor_y[k]),
            .i_z     (cor_z[k]),
            .o_valid (cor_valid[k+1]),
            .o_flags (cor_flags[k+1]),
            .o_x     (cor_x[k+1]),
            .o_y     (cor_y[k+1]),
            .o_z     (cor_z[k+1])
        );
    end

    // Output stage: round half up to Q3.13, saturate to +/- pi, apply the special cases.
    logic                      r_out_zero;
    logic signed [ANGLE_W-1:0] r_out_angle;
    logic signed [ANGLE_W-1:0] n_angle;
    t_z                        z_sum, z_rnd;
    t_flags                    fin_flags;

    assign fin_flags = cor_flags[N];

    always_comb begin
        z_sum = cor_z[N] + t_z'(1 << (ROUND_SHIFT - 1));
        z_rnd = z_sum >>> ROUND_SHIFT;
        if (fin_flags.zero_length) begin
            n_angle = '0;
        end else if (fin_flags.collinear) begin
            n_angle = fin_flags.dot_pos ? '0 : PI_OUT;
        end else if (z_rnd > t_z'(PI_OUT)) begin
            n_angle = PI_OUT;
        end else if (z_rnd < -t_z'(PI_OUT)) begin
            n_angle = -PI_OUT;
        end else begin
            n_angle = z_rnd[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cor_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_angle <= n_angle;
            r_out_zero  <= fin_flags.zero_length;
        end
    end

    assign o_angle.valid       = r_out_valid;
    assign o_angle.angle       = r_out_angle;
    assign o_angle.zero_length = r_out_zero;

    // A zero-length result always carries a zero angle.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid && o_angle.zero_length |-> o_angle.angle == '0)
        else $error("zero-length result with nonzero angle");

    // Every result lies within +/- pi.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |-> (o_angle.angle <= PI_OUT) && (o_angle.angle >= -PI_OUT))
        else $error("angle outside +/- pi");

    // A transfer taken during a stall lands in the skid buffer.
    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !en |=> r_skid_full)
        else $error("input transfer lost during stall");

    // A buffered item stays put until the pipeline advances.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full && !en |=> r_skid_full && $stable(r_skid_ax) && $stable(r_skid_by))
        else $error("skid buffer dropped an item while stalled");

endmodule

`default_nettype wire

// ===== dv/sa2v_angle_checker.sv =====
`timescale 1ns / 1ps
// Checker for the signed angle block: predicts each result from the vector pair
// transfers it sees and compares against the angle channel. Uses the channel
// interfaces from rtl/core/sa2v_if.sv.

module sa2v_angle_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sa2v_pair_if  i_pair,
    sa2v_angle_if i_angle,
    input  logic  i_drained,
    output int    o_pending,
    output int    o_fail_count
);

    // Predictor constants: Q.20 accumulator, Q3.13 output.
    localparam int         STAGES      = 16;
    localparam int         DROP_BITS   = 7;
    localparam longint     HALF_TURN   = 64'sd25736;
    localparam longint     QUARTER_Z   = 64'sd1647099;
    localparam longint     NORM_FLOOR  = 64'sd1 << 56;
    localparam int         MAX_PRINTED = 50;

    localparam longint ATAN_Q20 [0:15] = '{
        64'sd823550, 64'sd486170, 64'sd256879, 64'sd130396,
        64'sd65451,  64'sd32757,  64'sd16383,  64'sd8192,
        64'sd4096,   64'sd2048,   64'sd1024,   64'sd512,
        64'sd256,    64'sd128,    64'sd64,     64'sd32
    };

    typedef struct packed {
        logic signed [15:0] angle;
        logic               zero_length;
    } t_angle_result;

    t_angle_result expected_angles[$];
    int            result_count;
    logic          drain_checked;

    initial begin
        o_pending     = 0;
        o_fail_count  = 0;
        result_count  = 0;
        drain_checked = 1'b0;
    end

    // Angle from the first vector to the second as a vectoring rotation of (dot, cross).
    // With 16-bit components the products need no pre-halving.
    function automatic t_angle_result predict_angle(input logic signed [15:0] ax,
                                                    input logic signed [15:0] ay,
                                                    input logic signed [15:0] bx,
                                                    input logic signed [15:0] by);
        t_angle_result r;
        longint        dot_p, cross_p, x, y, z, t, mag_x, mag_y, mag_max, dx, dy, q13;
        r.angle       = '0;
        r.zero_length = 1'b0;
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
            r.zero_length = 1'b1;
            return r;
        end
        dot_p   = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
        cross_p = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
        // Collinear pairs are exact: same direction is zero, opposite is +pi.
        if (cross_p == 0) begin
            r.angle = (dot_p > 0) ? 16'sd0 : 16'(HALF_TURN);
            return r;
        end
        x = dot_p;
        y = cross_p;
        z = 0;
        // A negative dot is first turned a quarter toward the positive x axis.
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_Z;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_Z;
            end
        end
        mag_x   = (x < 0) ? -x : x;
        mag_y   = (y < 0) ? -y : y;
        mag_max = (mag_x > mag_y) ? mag_x : mag_y;
        while (mag_max < NORM_FLOOR) begin
            mag_max = mag_max * 2;
            x       = x * 2;
            y       = y * 2;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q20[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q20[i];
            end
        end
        // Round half up to Q3.13, then saturate to plus or minus pi.
        q13 = (z + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
        if (q13 > HALF_TURN)
            q13 = HALF_TURN;
        if (q13 < -HALF_TURN)
            q13 = -HALF_TURN;
        r.angle = 16'(q13);
        return r;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTED)
            $display("%0t ERROR: %s", $time, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    // Record expectations on pair transfers and check angle transfers in order.
    always @(posedge i_clk) begin : monitor
        t_angle_result want;
        if (i_rst_n) begin
            if (i_pair.valid && i_pair.ready)
                expected_angles.push_back(predict_angle(i_pair.first_x, i_pair.first_y,
                                                        i_pair.second_x, i_pair.second_y));
            if (i_angle.valid && i_angle.ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_count));
                end else begin
                    want = expected_angles.pop_front();
                    if (i_angle.angle !== want.angle)
                        report_mismatch($sformatf("result %0d angle %0d, predicted %0d",
                                                  result_count, i_angle.angle, want.angle));
                    if (i_angle.zero_length !== want.zero_length)
                        report_mismatch($sformatf("result %0d zero_length %b, predicted %b",
                                                  result_count, i_angle.zero_length,
                                                  want.zero_length));
                end
                result_count = result_count + 1;
            end
            if (i_drained && !drain_checked) begin
                drain_checked = 1'b1;
                if (expected_angles.size() != 0)
                    report_mismatch($sformatf("%0d predicted results never arrived",
                                              expected_angles.size()));
            end
        end
        o_pending = expected_angles.size();
    end

endmodule

// ===== dv/tb_signed_angle_2d_vectors_top.sv =====
`timescale 1ns / 1ps
// Testbench top for signed_angle_2d_vectors_top: drives vector pairs and result
// backpressure, and gives the verdict. Uses the channel interfaces and
// sa2v_angle_checker.

module tb_signed_angle_2d_vectors_top;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;

    logic i_clk;
    logic i_rst_n;
    logic drained;
    int   pending;
    int   fail_count;

    // Idle percentages of the current phase, and long hold-off requests.
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   holds_requested;
    int   holds_served;

    sa2v_pair_if #(.COMPONENT_WIDTH(16)) pair_ch ();
    sa2v_angle_if                        angle_ch ();

    signed_angle_2d_vectors_top #(
        .COMPONENT_WIDTH (16),
        .ANGLE_ITERATIONS(16)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pair (pair_ch),
        .o_angle(angle_ch)
    );

    sa2v_angle_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (pair_ch),
        .i_angle     (angle_ch),
        .i_drained   (drained),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Known values on every input from time zero.
    initial begin
        i_rst_n            = 1'b0;
        drained            = 1'b0;
        pair_ch.valid      = 1'b0;
        pair_ch.first_x    = '0;
        pair_ch.first_y    = '0;
        pair_ch.second_x   = '0;
        pair_ch.second_y   = '0;
        angle_ch.ready     = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holds_requested    = 0;
        holds_served       = 0;
    end

    // Offers one vector pair and returns after its transfer; valid stays high.
    task automatic send_pair(input int ax, input int ay, input int bx, input int by);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            pair_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pair_ch.valid    = 1'b1;
        pair_ch.first_x  = 16'(ax);
        pair_ch.first_y  = 16'(ay);
        pair_ch.second_x = 16'(bx);
        pair_ch.second_y = 16'(by);
        do
            @(posedge i_clk);
        while (!pair_ch.ready);
    endtask

    function automatic int pick_edge_value();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // Random pairs: half full range, the rest small, collinear, zero and edge mixes.
    task automatic send_random_pair();
        int kind, px, py, k1, k2;
        kind = $urandom_range(9);
        if (kind <= 4) begin
            send_pair($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(65535));
        end else if (kind <= 6) begin
            send_pair(int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                      int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4);
        end else if (kind == 7) begin
            // Both vectors along one line, same or opposite direction.
            px = int'($urandom_range(200)) - 100;
            py = int'($urandom_range(200)) - 100;
            k1 = int'($urandom_range(600)) - 300;
            k2 = int'($urandom_range(600)) - 300;
            send_pair(px * k1, py * k1, px * k2, py * k2);
        end else if (kind == 8) begin
            if ($urandom_range(1) == 0)
                send_pair(0, 0, $urandom_range(65535), $urandom_range(65535));
            else
                send_pair($urandom_range(65535), $urandom_range(65535), 0, 0);
        end else begin
            send_pair(pick_edge_value(), pick_edge_value(),
                      pick_edge_value(), pick_edge_value());
        end
    endtask

    // Result backpressure; a requested hold-off keeps ready low for a long stretch.
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (holds_served < holds_requested) begin
                angle_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served = holds_served + 1;
            end
            angle_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pairs: zero vectors, collinear, quarter turns, extremes.
        send_pair(0, 0, 5, 7);
        send_pair(3, -2, 0, 0);
        send_pair(0, 0, 0, 0);
        send_pair(32767, 0, 32767, 0);
        send_pair(32767, 0, -32768, 0);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(1, 0, 0, 1);
        send_pair(1, 0, 0, -1);
        send_pair(1, 0, -1, 1);
        send_pair(1, 0, -1, -1);
        send_pair(-32768, -32768, -32768, -32768);
        send_pair(-32768, 32767, 32767, -32768);
        send_pair(32767, 32767, -32768, 32767);
        send_pair(1, 1, -32768, -32767);
        send_pair(32767, 1, 32767, 0);
        send_pair(-1, 0, -1, 1);
        send_pair(0, -32768, -32768, 0);
        send_pair(2, 4, -1, -2);
        send_pair(-32768, 0, 0, -32768);
        send_pair(1, 0, -32768, 1);
        send_pair(1, 0, -32768, -1);

        // Random phases: no idling (with one long hold-off), idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    holds_requested    = holds_requested + 1;
                end
                1: begin
                    sender_idle_pct    = 78;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 78;
                end
                default: begin
                    sender_idle_pct    = 18;
                    receiver_stall_pct = 18;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_pair();
        end

        @(negedge i_clk);
        pair_ch.valid = 1'b0;
        receiver_stall_pct = 0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        drained = 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("signed_angle_2d_vectors_top verification clean");
        else
            $display("signed_angle_2d_vectors_top verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("signed_angle_2d_vectors_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sa2v_pkg.sv
rtl/core/sa2v_if.sv
rtl/core/sa2v_cordic_stage.sv
rtl/core/signed_angle_2d_vectors_top.sv
dv/sa2v_angle_checker.sv
dv/tb_signed_angle_2d_vectors_top.sv
